// ----- src/mvp_pkg.sv -----
package mvp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAT_COUNT     = 3;
  localparam int DIM           = 4;
  localparam int MAT_SIZE      = DIM * DIM;

  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_VERTEX = 1'b1;

  typedef logic signed [31:0] word_t;
  typedef word_t [DIM-1:0] vec_t;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  coef_index;
    word_t       coef_value;
    word_t       pos_x;
    word_t       pos_y;
    word_t       pos_z;
    word_t       pos_w;
    word_t       color_r;
    word_t       color_g;
    word_t       color_b;
    word_t       color_a;
  } req_t;

  typedef struct packed {
    word_t clip_x;
    word_t clip_y;
    word_t clip_z;
    word_t clip_w;
    word_t out_r;
    word_t out_g;
    word_t out_b;
    word_t out_a;
    logic  culled;
  } rsp_t;

  typedef struct packed {
    logic       is_vtx;
    logic [5:0] idx;
    word_t      val;
    vec_t       vec;
    vec_t       color;
  } item_t;

endpackage

// ----- src/mvp_vertex_transform.sv -----
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | mvp_pkg::req_t (coefficient write or vertex)
// rsp     | out       | rsp_valid/rsp_ready  | mvp_pkg::rsp_t (clip position, colour, culled)
//
// One transaction per cycle unless rsp stalls; rsp is registered after the last stage.
// Each matrix takes three stages: 16 multipliers, pair sums, final sum with round and saturate.
// A coefficient write travels the pipeline and lands in its matrix at that matrix's entry stage.
// Reset clears all stage valid bits and all 48 coefficients to zero.
// A stall on rsp fills the empty stages before req_ready drops.
module mvp_vertex_transform #(
  parameter int FRAC_BITS = mvp_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mvp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mvp_pkg::rsp_t rsp
);

  localparam int NM = mvp_pkg::MAT_COUNT;
  localparam int ND = mvp_pkg::DIM;
  localparam int NS = mvp_pkg::MAT_SIZE;
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] WMAX = 66'sd2147483647;
  localparam logic signed [65:0] WMIN = -66'sd2147483648;

  mvp_pkg::item_t mi_item [NM+1];
  logic           mi_v    [NM+1];
  logic           mi_en   [NM+1];
  mvp_pkg::word_t coef    [NM][NS];

  assign mi_v[0]               = req_valid;
  assign req_ready             = mi_en[0];
  assign mi_item[0].is_vtx     = (req.req_type == mvp_pkg::REQ_VERTEX);
  assign mi_item[0].idx        = req.coef_index;
  assign mi_item[0].val        = req.coef_value;
  assign mi_item[0].vec        = {req.pos_w, req.pos_z, req.pos_y, req.pos_x};
  assign mi_item[0].color      = {req.color_a, req.color_b, req.color_g, req.color_r};

  for (genvar m = 0; m < NM; m++) begin : g_mat
    logic                  va, vb, vc;
    logic                  en_a, en_b, en_c;
    mvp_pkg::item_t        item_a, item_b, item_c;
    logic signed [63:0]    prod [NS];
    logic signed [64:0]    psum [2*ND];
    mvp_pkg::vec_t         res;

    assign en_c = !vc || mi_en[m+1];
    assign en_b = !vb || en_c;
    assign en_a = !va || en_b;
    assign mi_en[m] = en_a;

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int i = 0; i < NS; i++) begin
          coef[m][i] <= '0;
        end
      end else if (mi_v[m] && en_a && !mi_item[m].is_vtx
                   && mi_item[m].idx[5:4] == 2'(m)) begin
        coef[m][mi_item[m].idx[3:0]] <= mi_item[m].val;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        va <= 1'b0;
        vb <= 1'b0;
        vc <= 1'b0;
      end else begin
        if (en_a) va <= mi_v[m];
        if (en_b) vb <= va;
        if (en_c) vc <= vb;
      end
    end

    always_ff @(posedge clk) begin
      if (en_a) begin
        item_a <= mi_item[m];
        for (int c = 0; c < ND; c++) begin
          for (int r = 0; r < ND; r++) begin
            prod[c*ND + r] <= $signed(coef[m][c*ND + r]) * $signed(mi_item[m].vec[c]);
          end
        end
      end
      if (en_b) begin
        item_b <= item_a;
        for (int r = 0; r < ND; r++) begin
          psum[2*r]     <= 65'(prod[r])        + 65'(prod[ND + r]);
          psum[2*r + 1] <= 65'(prod[2*ND + r]) + 65'(prod[3*ND + r]);
        end
      end
      if (en_c) begin
        item_c <= '{is_vtx: item_b.is_vtx, idx: item_b.idx, val: item_b.val,
                    vec: res, color: item_b.color};
      end
    end

    always_comb begin
      logic signed [65:0] s;
      logic signed [65:0] sh;
      s  = '0;
      sh = '0;
      for (int r = 0; r < ND; r++) begin
        s  = 66'(psum[2*r]) + 66'(psum[2*r + 1]) + HALF;
        sh = s >>> FRAC_BITS;
        if (sh > WMAX) begin
          res[r] = 32'sh7fffffff;
        end else if (sh < WMIN) begin
          res[r] = 32'sh80000000;
        end else begin
          res[r] = sh[31:0];
        end
      end
    end

    assign mi_v[m+1]    = vc;
    assign mi_item[m+1] = item_c;
  end

  logic cull_next;

  assign cull_next  = mi_item[NM].vec[3][31] || (mi_item[NM].vec[3] == '0);
  assign mi_en[NM]  = !rsp_valid || rsp_ready || !mi_item[NM].is_vtx;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid <= mi_v[NM] && mi_item[NM].is_vtx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp_ready) begin
      rsp.clip_x <= mi_item[NM].vec[0];
      rsp.clip_y <= mi_item[NM].vec[1];
      rsp.clip_z <= mi_item[NM].vec[2];
      rsp.clip_w <= mi_item[NM].vec[3];
      rsp.out_r  <= cull_next ? '0 : mi_item[NM].color[0];
      rsp.out_g  <= cull_next ? '0 : mi_item[NM].color[1];
      rsp.out_b  <= cull_next ? '0 : mi_item[NM].color[2];
      rsp.out_a  <= cull_next ? '0 : mi_item[NM].color[3];
      rsp.culled <= cull_next;
    end
  end

  a_model_write : assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.req_type == mvp_pkg::REQ_COEF && req.coef_index[5:4] == 2'd0
    |=> coef[0][$past(req.coef_index[3:0])] == $past(req.coef_value))
    else $error("model coefficient write not stored");

  a_cull_colour : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.culled
    |-> rsp.out_r == '0 && rsp.out_g == '0 && rsp.out_b == '0 && rsp.out_a == '0
        && (rsp.clip_w[31] || rsp.clip_w == '0))
    else $error("culled vertex carries colour or positive w");

  a_last_stage_drain : assert property (@(posedge clk) disable iff (rst)
    mi_v[NM] && mi_item[NM].is_vtx && (!rsp_valid || rsp_ready) |=> rsp_valid)
    else $error("finished vertex not presented on rsp");

endmodule

// ----- tb/mvp_vertex_check_pkg.sv -----
`timescale 1ns / 100ps

package mvp_vertex_check_pkg;

  class vertex_scoreboard;
    mvp_pkg::word_t coefs[mvp_pkg::MAT_COUNT*mvp_pkg::MAT_SIZE];
    mvp_pkg::rsp_t expected_q[$];
    int mismatches;
    int vertices;
    int culled_seen;
    int coef_writes;

    function new();
      foreach (coefs[i]) coefs[i] = '0;
      mismatches = 0;
      vertices = 0;
      culled_seen = 0;
      coef_writes = 0;
    endfunction

    function mvp_pkg::word_t row_dot(int mat, int row, mvp_pkg::word_t v[mvp_pkg::DIM]);
      logic signed [67:0] acc;
      int c;
      acc = '0;
      for (c = 0; c < mvp_pkg::DIM; c++) begin
        acc = acc + $signed(coefs[mat*mvp_pkg::MAT_SIZE + c*mvp_pkg::DIM + row])
                  * $signed(v[c]);
      end
      acc = (acc + (68'sd1 <<< (mvp_pkg::FRAC_BITS_DEF - 1))) >>> mvp_pkg::FRAC_BITS_DEF;
      if (acc > 68'sd2147483647) return 32'sh7fffffff;
      if (acc < -68'sd2147483648) return 32'sh80000000;
      return mvp_pkg::word_t'(acc[31:0]);
    endfunction

    function mvp_pkg::rsp_t transform(mvp_pkg::req_t r);
      mvp_pkg::word_t cur[mvp_pkg::DIM];
      mvp_pkg::word_t nxt[mvp_pkg::DIM];
      mvp_pkg::rsp_t e;
      logic dropped;
      cur[0] = r.pos_x;
      cur[1] = r.pos_y;
      cur[2] = r.pos_z;
      cur[3] = r.pos_w;
      for (int m = 0; m < mvp_pkg::MAT_COUNT; m++) begin
        for (int i = 0; i < mvp_pkg::DIM; i++) nxt[i] = row_dot(m, i, cur);
        cur = nxt;
      end
      dropped = ($signed(cur[3]) <= 0);
      e.clip_x = cur[0];
      e.clip_y = cur[1];
      e.clip_z = cur[2];
      e.clip_w = cur[3];
      e.out_r  = dropped ? '0 : r.color_r;
      e.out_g  = dropped ? '0 : r.color_g;
      e.out_b  = dropped ? '0 : r.color_b;
      e.out_a  = dropped ? '0 : r.color_a;
      e.culled = dropped;
      return e;
    endfunction

    function void note_request(mvp_pkg::req_t r);
      mvp_pkg::rsp_t e;
      if (r.req_type == mvp_pkg::REQ_COEF) begin
        if (r.coef_index < mvp_pkg::MAT_COUNT*mvp_pkg::MAT_SIZE) begin
          coefs[r.coef_index] = r.coef_value;
          coef_writes++;
        end
      end else begin
        e = transform(r);
        expected_q = {expected_q, e};
        vertices++;
        if (e.culled) culled_seen++;
      end
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      if (mismatches < 10) begin
        $display("%0t: %s expected %h, got %h", $time, what, want, got);
      end
      mismatches++;
    endfunction

    function void check_response(mvp_pkg::rsp_t got);
      mvp_pkg::rsp_t want;
      logic [$bits(mvp_pkg::rsp_t)-1:0] wb;
      logic [$bits(mvp_pkg::rsp_t)-1:0] gb;
      string names[8];
      int top;
      names = '{"clip_x", "clip_y", "clip_z", "clip_w", "out_r", "out_g", "out_b", "out_a"};
      top = $bits(mvp_pkg::rsp_t) - 1;
      if (expected_q.size() == 0) begin
        flag("unexpected transaction, clip_x", 32'h0, got.clip_x);
        return;
      end
      want = expected_q.pop_front();
      wb = want;
      gb = got;
      for (int i = 0; i < 8; i++) begin
        if (wb[top - 32*i -: 32] !== gb[top - 32*i -: 32]) begin
          flag(names[i], wb[top - 32*i -: 32], gb[top - 32*i -: 32]);
        end
      end
      if (want.culled !== got.culled) flag("culled", {31'b0, want.culled}, {31'b0, got.culled});
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ----- tb/mvp_vertex_transform_test.sv -----
`timescale 1ns / 100ps

module mvp_vertex_transform_test;

  localparam int ITEMS      = 1200;
  localparam int QUIET_TAIL = 150;
  localparam int COEF_COUNT = mvp_pkg::MAT_COUNT * mvp_pkg::MAT_SIZE;
  localparam mvp_pkg::word_t ONE   = 32'sh00010000;
  localparam mvp_pkg::word_t W_MAX = 32'sh7fffffff;
  localparam mvp_pkg::word_t W_MIN = 32'sh80000000;

  logic           clk = 1'b0;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  mvp_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_ready;
  mvp_pkg::rsp_t  rsp;

  logic  quiet = 1'b0;
  int    sent = 0;
  int    gap_rate = 0;
  mvp_vertex_check_pkg::vertex_scoreboard sb = new();

  mvp_vertex_transform uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
    end
  end

  function mvp_pkg::word_t extreme_word();
    case ($urandom_range(0, 6))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return 32'sd1;
      4: return -32'sd1;
      5: return ONE;
      default: return -ONE;
    endcase
  endfunction

  function mvp_pkg::word_t small_word(int span);
    return mvp_pkg::word_t'($signed(32'($urandom_range(0, 2*span))) - span);
  endfunction

  function mvp_pkg::word_t rand_word();
    case ($urandom_range(0, 3))
      0: return mvp_pkg::word_t'($urandom);
      1: return small_word(32'h40000);
      2: return extreme_word();
      default: return mvp_pkg::word_t'($signed($urandom) >>> $urandom_range(0, 24));
    endcase
  endfunction

  function mvp_pkg::req_t coef_req(int idx, mvp_pkg::word_t val);
    mvp_pkg::req_t r;
    r.req_type   = mvp_pkg::REQ_COEF;
    r.coef_index = 6'(idx);
    r.coef_value = val;
    r.pos_x      = mvp_pkg::word_t'($urandom);
    r.pos_y      = mvp_pkg::word_t'($urandom);
    r.pos_z      = mvp_pkg::word_t'($urandom);
    r.pos_w      = mvp_pkg::word_t'($urandom);
    r.color_r    = mvp_pkg::word_t'($urandom);
    r.color_g    = mvp_pkg::word_t'($urandom);
    r.color_b    = mvp_pkg::word_t'($urandom);
    r.color_a    = mvp_pkg::word_t'($urandom);
    return r;
  endfunction

  function mvp_pkg::req_t vertex_req(mvp_pkg::word_t x, mvp_pkg::word_t y,
                                     mvp_pkg::word_t z, mvp_pkg::word_t w);
    mvp_pkg::req_t r;
    r.req_type   = mvp_pkg::REQ_VERTEX;
    r.coef_index = 6'($urandom);
    r.coef_value = mvp_pkg::word_t'($urandom);
    r.pos_x      = x;
    r.pos_y      = y;
    r.pos_z      = z;
    r.pos_w      = w;
    r.color_r    = mvp_pkg::word_t'($urandom);
    r.color_g    = mvp_pkg::word_t'($urandom);
    r.color_b    = mvp_pkg::word_t'($urandom);
    r.color_a    = mvp_pkg::word_t'($urandom);
    return r;
  endfunction

  task hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  task send(mvp_pkg::req_t r);
    if (!quiet && gap_rate > 0 && $urandom_range(0, 99) < gap_rate) begin
      hold_off($urandom_range(1, 17));
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    if (!(r.req_type == mvp_pkg::REQ_COEF && r.coef_index >= COEF_COUNT)) sent++;
    quiet = (sent >= ITEMS - QUIET_TAIL);
  endtask

  function mvp_pkg::word_t pos_word();
    return ($urandom_range(0, 4) == 0) ? rand_word() : small_word(32'h40000);
  endfunction

  task load_matrix(int m, bit wild);
    for (int i = 0; i < mvp_pkg::MAT_SIZE; i++) begin
      send(coef_req(m*mvp_pkg::MAT_SIZE + i, wild ? rand_word() : small_word(32'h20000)));
    end
  endtask

  initial begin
    bit stall;
    int n;
    rsp_ready = 1'b0;
    forever begin
      if (quiet) begin
        @(negedge clk);
        rsp_ready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 2) == 0);
        n = stall ? $urandom_range(1, 17) : $urandom_range(1, 40);
        repeat (n) begin
          @(negedge clk);
          rsp_ready <= !stall;
        end
      end
    end
  end

  initial begin
    int k;
    int n;
    bit drained;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    drained   = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send(vertex_req(rand_word(), rand_word(), rand_word(), ONE));
    for (int m = 0; m < mvp_pkg::MAT_COUNT; m++) begin
      for (int c = 0; c < mvp_pkg::DIM; c++) begin
        send(coef_req(m*mvp_pkg::MAT_SIZE + c*mvp_pkg::DIM + c, ONE));
      end
    end
    send(vertex_req(ONE, -32'sh28000, 32'sh30000, ONE));
    send(vertex_req(W_MAX, W_MIN, W_MAX, W_MIN));
    send(vertex_req(W_MIN, W_MAX, W_MIN, W_MAX));
    send(vertex_req(ONE, ONE, ONE, '0));
    send(vertex_req(ONE, ONE, ONE, -32'sd1));
    send(coef_req(0, W_MAX));
    send(vertex_req(W_MAX, '0, '0, ONE));
    send(vertex_req(W_MIN, '0, '0, ONE));
    send(coef_req(COEF_COUNT, mvp_pkg::word_t'($urandom)));
    send(coef_req(63, mvp_pkg::word_t'($urandom)));
    send(coef_req(0, 32'sh8000));
    send(vertex_req(32'sd1, '0, '0, ONE));
    send(vertex_req(-32'sd1, '0, '0, ONE));
    send(vertex_req(32'sd3, -32'sd3, '0, ONE));

    while (sent < ITEMS) begin
      case ($urandom_range(0, 3))
        0: gap_rate = 0;
        1: gap_rate = 5;
        2: gap_rate = 20;
        default: gap_rate = 50;
      endcase
      case ($urandom_range(0, 3))
        0: for (int m = 0; m < mvp_pkg::MAT_COUNT; m++) load_matrix(m, 1'b0);
        1: load_matrix($urandom_range(0, mvp_pkg::MAT_COUNT - 1), $urandom_range(0, 9) == 0);
        2: repeat ($urandom_range(1, 4)) begin
             send(coef_req($urandom_range(0, COEF_COUNT - 1), rand_word()));
           end
        default: ;
      endcase
      n = $urandom_range(10, 60);
      while (n > 0 && sent < ITEMS) begin
        k = $urandom_range(0, 99);
        if (k < 5) send(coef_req($urandom_range(0, COEF_COUNT - 1), small_word(32'h20000)));
        else if (k < 7) send(coef_req($urandom_range(COEF_COUNT, 63), mvp_pkg::word_t'($urandom)));
        else send(vertex_req(pos_word(), pos_word(), pos_word(), pos_word()));
        n--;
      end
      if (!drained && sent >= ITEMS / 2) begin
        // hold the sender until every expected vertex response has arrived
        hold_off(1);
        while (sb.pending() != 0) @(negedge clk);
        drained = 1'b1;
      end
    end

    hold_off(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d vertices (%0d culled) against %0d coefficient writes,",
             sb.vertices, sb.culled_seen, sb.coef_writes);
    $display("with bursty gaps and back-pressure; %0d field mismatches.", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mvp_pkg.sv
src/mvp_vertex_transform.sv
tb/mvp_vertex_check_pkg.sv
tb/mvp_vertex_transform_test.sv
